// ----- rtl/core/cbf_pkg.sv -----
// Shared types, constants and helpers for the clipped rectangle fill/copy engine.
package cbf_pkg;

    localparam int SCREEN_WIDTH  = 1280;
    localparam int SCREEN_HEIGHT = 720;
    localparam int PIXEL_BYTES   = 2;
    localparam int PIX_SHIFT     = $clog2(PIXEL_BYTES);

    localparam int COORD_W    = 12;
    localparam int POS_W      = COORD_W + 2;
    localparam int SIZE_W     = 13;
    localparam int OFFSET_W   = 24;
    localparam int PITCH_W    = 14;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 25;
    localparam int PROD_W     = COORD_W + PITCH_W;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int MID_DEPTH  = 2;
    localparam int OUT_DEPTH  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEST_X      = 3'd0,
        REG_DEST_Y      = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_BASE_OFFSET = 3'd4,
        REG_LINE_PITCH  = 3'd5,
        REG_FILL_MODE   = 3'd6,
        REG_FILL_COLOR  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0]  dest_x;
        logic [COORD_W-1:0]  dest_y;
        logic [SIZE_W-1:0]   rect_width;
        logic [SIZE_W-1:0]   rect_height;
        logic [OFFSET_W-1:0] base_offset;
        logic [PITCH_W-1:0]  line_pitch;
        logic                fill_mode;
        logic [COLOR_W-1:0]  fill_color;
    } t_cfg;

    // One classified pixel slot travelling from the front to the back.
    typedef struct packed {
        logic [COLOR_W-1:0] colour;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               on_screen;
        logic               last;
    } t_slot;

    typedef struct packed {
        logic               write_enable;
        logic [ADDR_W-1:0]  write_address;
        logic [COLOR_W-1:0] write_data;
        logic               last_pixel;
    } t_result;

    // Last valid counter index for a rectangle size; zero acts as one,
    // anything above 4096 acts as 4096.
    function automatic logic [COORD_W-1:0] size_last(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] dec;
        dec = size - SIZE_W'(1);
        if (size == '0) begin
            return '0;
        end else if (size > SIZE_W'(1 << COORD_W)) begin
            return '1;
        end else begin
            return dec[COORD_W-1:0];
        end
    endfunction

endpackage

// ----- rtl/core/cbf_fifo.sv -----
// Small flip-flop queue used between the engine stages and at the result side.
module cbf_fifo
    import cbf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/cbf_front.sv -----
// Front end: slot counters, colour selection and screen clipping.
module cbf_front
    import cbf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_accept,
    input  logic [COLOR_W-1:0] i_source_pixel,
    output t_slot              o_slot
);
    logic [COORD_W-1:0] r_col, r_row, n_col, n_row;
    logic [COORD_W-1:0] w_last, h_last;
    logic               row_end, col_end;
    logic [POS_W-1:0]   px, py;

    assign w_last  = size_last(i_cfg.rect_width);
    assign h_last  = size_last(i_cfg.rect_height);
    assign row_end = (r_col >= w_last);
    assign col_end = (r_row >= h_last);

    // Sign-extended origin plus zero-extended counter; bit POS_W-1 is the sign.
    assign px = {{2{i_cfg.dest_x[COORD_W-1]}}, i_cfg.dest_x} + {2'b00, r_col};
    assign py = {{2{i_cfg.dest_y[COORD_W-1]}}, i_cfg.dest_y} + {2'b00, r_row};

    always_comb begin
        o_slot.colour    = i_cfg.fill_mode ? i_cfg.fill_color : i_source_pixel;
        o_slot.px        = px[COORD_W-1:0];
        o_slot.py        = py[COORD_W-1:0];
        o_slot.on_screen = !px[POS_W-1] && (px < POS_W'(SCREEN_WIDTH))
                        && !py[POS_W-1] && (py < POS_W'(SCREEN_HEIGHT));
        o_slot.last      = row_end && col_end;

        n_col = r_col;
        n_row = r_row;
        if (i_accept) begin
            if (row_end) begin
                n_col = '0;
                n_row = col_end ? '0 : r_row + COORD_W'(1);
            end else begin
                n_col = r_col + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ----- rtl/core/cbf_back.sv -----
// Back end: byte address generation with one registered product stage.
module cbf_back
    import cbf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [PITCH_W-1:0]  i_line_pitch,
    input  logic [OFFSET_W-1:0] i_base_offset,
    input  logic                i_valid,
    input  t_slot               i_slot,
    output logic                o_take,
    input  logic                i_out_full,
    output logic                o_res_valid,
    output t_result             o_res
);
    logic               r_valid;
    t_slot              r_slot;
    logic [ADDR_W-1:0]  r_prod;
    logic               advance;
    logic [ADDR_W-1:0]  sum;

    assign advance     = r_valid && !i_out_full;
    assign o_take      = i_valid && (!r_valid || advance);
    assign o_res_valid = advance;

    // Row term is registered; column and pan terms join it in the next cycle.
    assign sum = r_prod
               + (ADDR_W'(r_slot.px) << PIX_SHIFT)
               + ADDR_W'(i_base_offset);

    always_comb begin
        o_res.write_enable  = r_slot.on_screen && (r_slot.colour != '0);
        o_res.write_address = r_slot.on_screen ? sum : '0;
        o_res.write_data    = r_slot.colour;
        o_res.last_pixel    = r_slot.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_slot <= i_slot;
            r_prod <= ADDR_W'(PROD_W'(i_slot.py) * PROD_W'(i_line_pitch));
        end
    end

endmodule

// ----- rtl/core/clipped_rect_fill_blit.sv -----
// Top level of the clipped rectangle fill/copy engine for a 16-bit framebuffer.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  ----------------------------------------
//   config    in         i_cfg_we              i_cfg_index, i_cfg_data
//   pixel     in         push / full           i_source_pixel
//   write     out        empty / pop           o_write_enable, o_write_address,
//                                              o_write_data, o_last_pixel
//
// One request is taken every clock while full is low, and one write result leaves
// every clock while pop is held and empty is low; a result reaches the result ports
// after it has passed the middle queue, the registered row-times-pitch product and
// the result queue, and can be popped from then on.
// Reset is synchronous and active low; it loads the register defaults and zeroes
// the slot counters and all queues. A stall at the result side fills the result
// queue, then the back stage, then the middle queue, and only then raises full.
module clipped_rect_fill_blit
    import cbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [COLOR_W-1:0]    i_source_pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_write_enable,
    output logic [ADDR_W-1:0]     o_write_address,
    output logic [COLOR_W-1:0]    o_write_data,
    output logic                  o_last_pixel
);
    t_cfg    r_cfg;
    t_slot   front_slot, mid_slot;
    logic    mid_full, mid_empty, mid_take;
    logic    accept;
    logic    res_valid, out_full;
    t_result back_res, out_res;
    logic [$bits(t_slot)-1:0]   mid_rd_bits;
    logic [$bits(t_result)-1:0] out_rd_bits;

    // Register file. Writes must arrive only while the engine is idle, which the
    // block does not enforce. The front and back stages read them with no shadow copy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_x      <= '0;
            r_cfg.dest_y      <= '0;
            r_cfg.rect_width  <= SIZE_W'(1);
            r_cfg.rect_height <= SIZE_W'(1);
            r_cfg.base_offset <= '0;
            r_cfg.line_pitch  <= PITCH_W'(2560);
            r_cfg.fill_mode   <= 1'b1;
            r_cfg.fill_color  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_DEST_X:      r_cfg.dest_x      <= i_cfg_data[COORD_W-1:0];
                REG_DEST_Y:      r_cfg.dest_y      <= i_cfg_data[COORD_W-1:0];
                REG_RECT_WIDTH:  r_cfg.rect_width  <= i_cfg_data[SIZE_W-1:0];
                REG_RECT_HEIGHT: r_cfg.rect_height <= i_cfg_data[SIZE_W-1:0];
                REG_BASE_OFFSET: r_cfg.base_offset <= i_cfg_data[OFFSET_W-1:0];
                REG_LINE_PITCH:  r_cfg.line_pitch  <= i_cfg_data[PITCH_W-1:0];
                REG_FILL_MODE:   r_cfg.fill_mode   <= i_cfg_data[0];
                REG_FILL_COLOR:  r_cfg.fill_color  <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // A request is taken whenever the middle queue has room.
    assign full   = mid_full;
    assign accept = push && !mid_full;

    // The front end classifies the slot in the accepting cycle and steps the
    // row-major counters.
    cbf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_source_pixel (i_source_pixel),
        .o_slot         (front_slot)
    );

    // The middle queue decouples classification from address generation.
    cbf_fifo #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_slot),
        .o_full  (mid_full),
        .i_pop   (mid_take),
        .o_data  (mid_rd_bits),
        .o_empty (mid_empty)
    );

    assign mid_slot = t_slot'(mid_rd_bits);

    // The back end forms the byte address and applies the colour key.
    cbf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_pitch  (r_cfg.line_pitch),
        .i_base_offset (r_cfg.base_offset),
        .i_valid       (!mid_empty),
        .i_slot        (mid_slot),
        .o_take        (mid_take),
        .i_out_full    (out_full),
        .o_res_valid   (res_valid),
        .o_res         (back_res)
    );

    // Finished results wait here, so a stalled consumer does not block the back end
    // until the queue is full.
    cbf_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_rd_bits),
        .o_empty (empty)
    );

    assign out_res         = t_result'(out_rd_bits);
    assign o_write_enable  = out_res.write_enable;
    assign o_write_address = out_res.write_address;
    assign o_write_data    = out_res.write_data;
    assign o_last_pixel    = out_res.last_pixel;

endmodule

// ----- tb/sv/cbf_write_checker.sv -----
// Watches the pixel, config and write channels, predicts every write result and compares it.
`timescale 1ns / 1ps

module cbf_write_checker
    import cbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic [COLOR_W-1:0]    i_source_pixel,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  logic                  i_write_enable,
    input  logic [ADDR_W-1:0]     i_write_address,
    input  logic [COLOR_W-1:0]    i_write_data,
    input  logic                  i_last_pixel,
    output int                    o_fail_count,
    output int                    o_pending
);

    t_cfg               cfg;
    logic [COORD_W-1:0] slot_col;
    logic [COORD_W-1:0] slot_row;
    t_result            pending_writes[$];
    int                 fails = 0;
    int                 pending_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_count;

    // Classifies the current slot, then advances the row-major slot counters.
    function automatic t_result predict_write(input logic [COLOR_W-1:0] src);
        t_result            r;
        logic [COLOR_W-1:0] colour;
        int                 px;
        int                 py;
        int                 col_last;
        int                 row_last;
        longint             sum;
        logic               on_screen;
        logic               row_end;
        logic               col_end;
        colour = cfg.fill_mode ? cfg.fill_color : src;
        px = int'($signed(cfg.dest_x)) + int'(slot_col);
        py = int'($signed(cfg.dest_y)) + int'(slot_row);
        on_screen = (px >= 0) && (px < SCREEN_WIDTH) && (py >= 0) && (py < SCREEN_HEIGHT);
        col_last = (cfg.rect_width == '0) ? 0 :
                   (cfg.rect_width > 13'd4096) ? 4095 : int'(cfg.rect_width) - 1;
        row_last = (cfg.rect_height == '0) ? 0 :
                   (cfg.rect_height > 13'd4096) ? 4095 : int'(cfg.rect_height) - 1;
        row_end = int'(slot_col) >= col_last;
        col_end = int'(slot_row) >= row_last;
        sum = longint'(px) * PIXEL_BYTES + longint'(py) * longint'(cfg.line_pitch)
            + longint'(cfg.base_offset);
        r.write_enable  = on_screen && (colour != '0);
        r.write_address = on_screen ? ADDR_W'(sum) : '0;
        r.write_data    = colour;
        r.last_pixel    = row_end && col_end;
        if (row_end) begin
            slot_col = '0;
            slot_row = col_end ? '0 : slot_row + 1'b1;
        end else begin
            slot_col = slot_col + 1'b1;
        end
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
        fails++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg.dest_x      = '0;
            cfg.dest_y      = '0;
            cfg.rect_width  = 13'd1;
            cfg.rect_height = 13'd1;
            cfg.base_offset = '0;
            cfg.line_pitch  = 14'd2560;
            cfg.fill_mode   = 1'b1;
            cfg.fill_color  = '0;
            slot_col = '0;
            slot_row = '0;
            pending_writes.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_writes.size() == 0) begin
                    $display("%0t ns: write result with none expected, got en %0b addr 0x%0h",
                             $time, i_write_enable, i_write_address);
                    fails++;
                end else begin
                    want = pending_writes.pop_front();
                    if (want.write_enable != i_write_enable)
                        report("write_enable", 32'(want.write_enable), 32'(i_write_enable));
                    if (want.write_address != i_write_address)
                        report("write_address", 32'(want.write_address),
                               32'(i_write_address));
                    if (want.write_data != i_write_data)
                        report("write_data", 32'(want.write_data), 32'(i_write_data));
                    if (want.last_pixel != i_last_pixel)
                        report("last_pixel", 32'(want.last_pixel), 32'(i_last_pixel));
                end
            end
            if (i_push && !i_full) begin
                pending_writes.insert(pending_writes.size(), predict_write(i_source_pixel));
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_DEST_X:      cfg.dest_x      = i_cfg_data[COORD_W-1:0];
                    REG_DEST_Y:      cfg.dest_y      = i_cfg_data[COORD_W-1:0];
                    REG_RECT_WIDTH:  cfg.rect_width  = i_cfg_data[SIZE_W-1:0];
                    REG_RECT_HEIGHT: cfg.rect_height = i_cfg_data[SIZE_W-1:0];
                    REG_BASE_OFFSET: cfg.base_offset = i_cfg_data[OFFSET_W-1:0];
                    REG_LINE_PITCH:  cfg.line_pitch  = i_cfg_data[PITCH_W-1:0];
                    REG_FILL_MODE:   cfg.fill_mode   = i_cfg_data[0];
                    REG_FILL_COLOR:  cfg.fill_color  = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
        end
        pending_count = pending_writes.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// Stimulus and verdict for the clipped rectangle fill/copy engine, with the checker beside it.
`timescale 1ns / 1ps

module tb_top;
    import cbf_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    logic                  full;
    logic [COLOR_W-1:0]    source_pixel;
    logic                  empty;
    logic                  pop;
    logic                  write_enable;
    logic [ADDR_W-1:0]     write_address;
    logic [COLOR_W-1:0]    write_data;
    logic                  last_pixel;

    int                    fail_count;
    int                    pending;

    // Set by the stimulus process, read by the receiver: calm turns off all idling for the
    // closing stretch, and hold_pop asks the receiver for one long hold-off.
    bit                    calm = 1'b0;
    bit                    hold_pop = 1'b0;
    logic                  push_taken = 1'b0;
    logic [COLOR_W-1:0]    pixels_to_send[$];
    int                    items_sent = 0;
    t_cfg                  cfg_now;

    always #2 i_clk = ~i_clk;

    clipped_rect_fill_blit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .push            (push),
        .full            (full),
        .i_source_pixel  (source_pixel),
        .empty           (empty),
        .pop             (pop),
        .o_write_enable  (write_enable),
        .o_write_address (write_address),
        .o_write_data    (write_data),
        .o_last_pixel    (last_pixel)
    );

    cbf_write_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_push          (push),
        .i_full          (full),
        .i_source_pixel  (source_pixel),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_write_enable  (write_enable),
        .i_write_address (write_address),
        .i_write_data    (write_data),
        .i_last_pixel    (last_pixel),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Records at each rising edge whether the pixel request on the port was taken. The
    // sender reads it at the following falling edge, when it has settled.
    always @(posedge i_clk) begin
        push_taken <= i_rst_n && push && !full;
    end

    // Writes one register. The caller lowers the write enable after its last write so the
    // enable is never dropped and raised within one time step. Bits above the register's
    // width are sometimes filled with noise, which the block must ignore.
    task automatic put_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((longint'(1) << width) - 1);
        cfg_we    = 1'b1;
        cfg_index = idx;
        if ($urandom_range(0, 3) == 0) begin
            cfg_data = (CFG_DATA_W'($urandom) & ~keep) | value;
        end else begin
            cfg_data = value;
        end
        @(negedge i_clk);
    endtask

    // Rewrites the whole register set. Config writes never touch the slot
    // counters, so a rectangle left unfinished carries on under the new settings.
    task automatic load_config(input t_cfg c);
        put_reg(REG_DEST_X,      CFG_DATA_W'(c.dest_x),      COORD_W);
        put_reg(REG_DEST_Y,      CFG_DATA_W'(c.dest_y),      COORD_W);
        put_reg(REG_RECT_WIDTH,  CFG_DATA_W'(c.rect_width),  SIZE_W);
        put_reg(REG_RECT_HEIGHT, CFG_DATA_W'(c.rect_height), SIZE_W);
        put_reg(REG_BASE_OFFSET, CFG_DATA_W'(c.base_offset), OFFSET_W);
        put_reg(REG_LINE_PITCH,  CFG_DATA_W'(c.line_pitch),  PITCH_W);
        put_reg(REG_FILL_MODE,   CFG_DATA_W'(c.fill_mode),   1);
        put_reg(REG_FILL_COLOR,  CFG_DATA_W'(c.fill_color),  COLOR_W);
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
    endtask

    // Appends one source pixel to the send list.
    task automatic queue_pixel(input logic [COLOR_W-1:0] value);
        pixels_to_send.insert(pixels_to_send.size(), value);
    endtask

    // Offers every queued source pixel in order, with random gaps unless the run is calm.
    // A request stays on the port until the block takes it.
    task automatic stream_pixels();
        while (pixels_to_send.size() > 0) begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                push = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            push         = 1'b1;
            source_pixel = pixels_to_send.pop_front();
            do @(negedge i_clk); while (!push_taken);
            items_sent++;
        end
        push = 1'b0;
    endtask

    // The block is idle once the checker holds no expectation; the task then lets the
    // pipeline settle before the registers change.
    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic run_phase();
        load_config(cfg_now);
        stream_pixels();
        wait_drained();
    endtask

    // Coordinates cluster around both screen edges and the signed extremes, where the
    // clipping decisions flip.
    function automatic logic [COORD_W-1:0] random_coord(input int span);
        case ($urandom_range(0, 4))
            0:       return COORD_W'($urandom);
            1:       return COORD_W'(int'($urandom_range(0, 8)) - 4);
            2:       return COORD_W'(span - 6 + int'($urandom_range(0, 8)));
            3:       return $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
            default: return COORD_W'($urandom_range(0, span - 1));
        endcase
    endfunction

    // Mostly small rectangles so that many complete ones fit in the run; zero and oversize
    // values show up regularly.
    function automatic logic [SIZE_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'($urandom_range(4096, 8191));
            2:       return SIZE_W'($urandom_range(1, 4096));
            default: return SIZE_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic int slots_per_side(input logic [SIZE_W-1:0] size);
        if (size == '0) return 1;
        if (size > 13'd4096) return 4096;
        return int'(size);
    endfunction

    function automatic t_cfg random_config();
        t_cfg c;
        c.dest_x      = random_coord(SCREEN_WIDTH);
        c.dest_y      = random_coord(SCREEN_HEIGHT);
        c.rect_width  = random_size();
        c.rect_height = random_size();
        case ($urandom_range(0, 3))
            0:       c.base_offset = '0;
            1:       c.base_offset = '1;
            default: c.base_offset = OFFSET_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       c.line_pitch = '0;
            1:       c.line_pitch = '1;
            2:       c.line_pitch = 14'd2560;
            default: c.line_pitch = PITCH_W'($urandom);
        endcase
        c.fill_mode  = 1'($urandom_range(0, 1));
        c.fill_color = ($urandom_range(0, 3) == 0) ? '0 : COLOR_W'($urandom);
        return c;
    endfunction

    task automatic queue_random_pixels(input int n);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_pixel('0);
            end else begin
                queue_pixel(COLOR_W'($urandom));
            end
        end
    endtask

    // Receiver: pops with random stalls, and once holds off for a long counted stretch so
    // that the result side backs up all the way to full.
    initial begin
        pop = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_pop) begin
                pop = 1'b0;
                repeat (100) @(negedge i_clk);
                hold_pop = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                pop = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Main stimulus: reset, directed phases, random phases, then the verdict.
    initial begin
        int area;
        int n;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        push         = 1'b0;
        source_pixel = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset defaults: a 1x1 fill with colour zero is keyed out but still flags last.
        queue_pixel(16'hFFFF);
        stream_pixels();
        wait_drained();

        // Rectangle entirely off screen at the most negative corner.
        cfg_now.dest_x      = 12'h800;
        cfg_now.dest_y      = 12'h800;
        cfg_now.rect_width  = 13'd2;
        cfg_now.rect_height = 13'd2;
        cfg_now.base_offset = '0;
        cfg_now.line_pitch  = '0;
        cfg_now.fill_mode   = 1'b1;
        cfg_now.fill_color  = 16'hFFFF;
        queue_random_pixels(4);
        run_phase();

        // Straddling the bottom right corner with the largest offset and pitch, so some
        // slots are clipped and the on-screen ones produce the largest addresses.
        cfg_now.dest_x      = 12'd1278;
        cfg_now.dest_y      = 12'd718;
        cfg_now.rect_width  = 13'd3;
        cfg_now.rect_height = 13'd3;
        cfg_now.base_offset = '1;
        cfg_now.line_pitch  = '1;
        cfg_now.fill_color  = 16'h0001;
        queue_random_pixels(9);
        run_phase();

        // Copy mode with zero sizes, which act as a single slot; a zero source is keyed.
        cfg_now.dest_x      = '0;
        cfg_now.dest_y      = '0;
        cfg_now.rect_width  = '0;
        cfg_now.rect_height = '0;
        cfg_now.base_offset = OFFSET_W'($urandom);
        cfg_now.line_pitch  = 14'd2560;
        cfg_now.fill_mode   = 1'b0;
        cfg_now.fill_color  = '0;
        queue_pixel('0);
        queue_pixel(16'hFFFF);
        queue_random_pixels(1);
        run_phase();

        // Part of a 10x10 rectangle, then the width shrinks below the current column so the
        // row must end at once.
        cfg_now.dest_x      = 12'h7FF;
        cfg_now.dest_y      = 12'd5;
        cfg_now.rect_width  = 13'd10;
        cfg_now.rect_height = 13'd10;
        queue_random_pixels(5);
        run_phase();
        cfg_now.dest_x     = 12'd1270;
        cfg_now.rect_width = 13'd3;
        queue_random_pixels(2);
        run_phase();

        // Oversize width and height act as 4096.
        cfg_now.dest_x      = '0;
        cfg_now.rect_width  = '1;
        cfg_now.rect_height = '1;
        cfg_now.fill_mode   = 1'b1;
        cfg_now.fill_color  = 16'h8000;
        queue_random_pixels(3);
        run_phase();

        // Long receiver hold-off while the sender keeps offering pixels.
        cfg_now  = random_config();
        hold_pop = 1'b1;
        queue_random_pixels(60);
        run_phase();

        // Random phases. Small rectangles are mostly sent whole once or twice; larger ones
        // stop partway so the next settings pick up mid-rectangle.
        while (items_sent < 1530) begin
            if (items_sent >= 1330) calm = 1'b1;
            cfg_now = random_config();
            area = slots_per_side(cfg_now.rect_width) * slots_per_side(cfg_now.rect_height);
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 30);
            end else if (area <= 48) begin
                n = area * int'($urandom_range(1, 2));
            end else begin
                n = $urandom_range(1, 48);
            end
            queue_random_pixels(n);
            run_phase();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("clipped_rect_fill_blit verification clean");
        end else begin
            $display("clipped_rect_fill_blit verification failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run with every gap and stall at its longest.
    initial begin
        #2000000;
        $display("clipped_rect_fill_blit verification failed");
        $finish;
    end

endmodule
